// File: rtl/hak_pkg.sv
// ----------------------------------------------------------------------------
// hak_pkg
// Shared codes, result layout and the candidate-index helper for the
// hunt-and-kill maze stepper.
// ----------------------------------------------------------------------------
package hak_pkg;

  localparam int OUT_TDATA_W = 24;

  localparam logic [2:0] EV_WALK    = 3'd0;
  localparam logic [2:0] EV_LINK    = 3'd1;
  localparam logic [2:0] EV_EMPTY   = 3'd2;
  localparam logic [2:0] EV_FINISH  = 3'd3;
  localparam logic [2:0] EV_RESTART = 3'd4;

  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_S = 2'd1;
  localparam logic [1:0] DIR_W = 2'd2;
  localparam logic [1:0] DIR_E = 2'd3;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  typedef struct packed {
    logic       found;
    logic [1:0] dir;
  } pick_t;

  // choice mod n for n in 1..4
  function automatic logic [1:0] mod_pick(input logic [7:0] c, input logic [2:0] n);
    logic [15:0] p;
    logic [7:0]  q;
    logic [7:0]  r;
    p = 16'(c) * 16'd171;
    q = 8'(p >> 9);
    r = 8'd0;
    case (n)
      3'd2:    r = {7'd0, c[0]};
      3'd3:    r = c - 8'(q * 8'd3);
      3'd4:    r = {6'd0, c[1:0]};
      default: r = 8'd0;
    endcase
    return r[1:0];
  endfunction

endpackage

// File: rtl/hak_map.sv
// ----------------------------------------------------------------------------
// hak_map
// Visited map: one word per grid row, one bit per column, registered read.
// ----------------------------------------------------------------------------
module hak_map #(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 32
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [$clog2(MAX_ROWS)-1:0] waddr_i,
  input  logic [MAX_COLS-1:0]         wdata_i,
  input  logic [$clog2(MAX_ROWS)-1:0] raddr_i,
  output logic [MAX_COLS-1:0]         rdata_o
);

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/hak_pick.sv
// ----------------------------------------------------------------------------
// hak_pick
// Neighbour test for one cell against three cached map rows and selection
// of the candidate given by the random choice.
// ----------------------------------------------------------------------------
module hak_pick #(
  parameter int MAX_COLS = 32
) (
  input  logic [MAX_COLS-1:0]         up_i,
  input  logic [MAX_COLS-1:0]         mid_i,
  input  logic [MAX_COLS-1:0]         dn_i,
  input  logic [$clog2(MAX_COLS):0]   col_i,
  input  logic [$clog2(MAX_COLS):0]   w_i,
  input  logic                        ok_up_i,
  input  logic                        ok_mid_i,
  input  logic                        ok_dn_i,
  input  logic                        want_i,
  input  logic [7:0]                  choice_i,
  output hak_pkg::pick_t              pick_o
);
  import hak_pkg::*;

  localparam int CW  = $clog2(MAX_COLS);
  localparam int CNW = CW + 1;

  logic [CW-1:0]  ci;
  logic [CW-1:0]  cw;
  logic [CW-1:0]  ce;
  logic [CNW-1:0] col_e;
  logic           c_ok;
  logic [3:0]     fl;
  logic [2:0]     n;
  logic [1:0]     k;
  logic [2:0]     cnt;
  logic [1:0]     dir;

  always_comb begin
    ci    = col_i[CW-1:0];
    cw    = CW'(col_i - CNW'(1));
    col_e = col_i + CNW'(1);
    ce    = CW'(col_e);
    c_ok  = col_i < w_i;
    fl[DIR_N] = ok_up_i && c_ok && (up_i[ci] == want_i);
    fl[DIR_S] = ok_dn_i && c_ok && (dn_i[ci] == want_i);
    fl[DIR_W] = ok_mid_i && (col_i != '0) && ((col_i - CNW'(1)) < w_i)
                && (mid_i[cw] == want_i);
    fl[DIR_E] = ok_mid_i && (col_e < w_i) && (mid_i[ce] == want_i);
    n   = 3'($countones(fl));
    k   = mod_pick(choice_i, n);
    cnt = 3'd0;
    dir = DIR_N;
    for (int d = 0; d < 4; d++) begin
      if (fl[d] && (cnt == {1'b0, k})) begin
        dir = 2'(d);
      end
      cnt = cnt + {2'd0, fl[d]};
    end
    pick_o.found = (n != 3'd0);
    pick_o.dir   = dir;
  end

endmodule

// File: rtl/hunt_and_kill_maze_stepper.sv
// ----------------------------------------------------------------------------
// hunt_and_kill_maze_stepper
// Hunt-and-kill maze generator stepped one beat at a time.
// ----------------------------------------------------------------------------
// Each tick beat yields one result beat. The visited map is a row-wide memory
// with one read port, so a walk or hunt tick first fetches the rows above, at
// and below the working row; a tick after finish, or one that finds the hunt
// past the last row, fetches nothing. A dead end adds a second fetch. A hunt
// tick walks the cached row one column per cycle. After reset and on restart
// a clearing pass over all MAX_ROWS map rows runs before the next beat is
// taken. Configuration writes are taken at any time and apply at once.
module hunt_and_kill_maze_stepper #(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // choice
  input  logic                             s_axis_tuser,   // operation
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // cell_col[4:0] cell_row[9:5] link_dir[11:10] scan_row[16:12] more[17]
  output logic [hak_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic [2:0]                       m_axis_tuser,   // event_res
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_index_i,
  input  logic [5:0]                       cfg_data_i
);
  import hak_pkg::*;

  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CNW = CW + 1;
  localparam int RNW = RW + 1;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_F0    = 4'd2;
  localparam logic [3:0] S_F1    = 4'd3;
  localparam logic [3:0] S_F2    = 4'd4;
  localparam logic [3:0] S_F3    = 4'd5;
  localparam logic [3:0] S_EVAL  = 4'd6;
  localparam logic [3:0] S_SCAN  = 4'd7;
  localparam logic [3:0] S_RES   = 4'd8;

  function automatic logic [MAX_COLS-1:0] oh(input logic [CW-1:0] i);
    return {{(MAX_COLS-1){1'b0}}, 1'b1} << i;
  endfunction

  logic [3:0]          state_q, state_d;
  logic [5:0]          cols_q, rows_q;
  logic [CW-1:0]       walk_col_q, walk_col_d;
  logic [RW-1:0]       walk_row_q, walk_row_d;
  logic                hunting_q, hunting_d;
  logic [RNW-1:0]      hunt_row_q, hunt_row_d;
  logic                finished_q, finished_d;
  logic                restart_q, restart_d;
  logic [RW-1:0]       clr_q, clr_d;
  logic [RW-1:0]       br_q, br_d;
  logic [CNW-1:0]      x_q, x_d;
  logic [7:0]          choice_q, choice_d;
  logic [MAX_COLS-1:0] up_q, up_d, mid_q, mid_d, dn_q, dn_d;
  logic [2:0]          ev_q, ev_d;
  logic [4:0]          rc_q, rc_d, rr_q, rr_d, rs_q, rs_d;
  logic [1:0]          rd_q, rd_d;
  logic                rm_q, rm_d;
  logic                m_tvalid_q, m_tvalid_d;
  logic [2:0]          m_tuser_q, m_tuser_d;
  logic [OUT_TDATA_W-1:0] m_tdata_q, m_tdata_d;

  logic [CNW-1:0]      w;
  logic [RNW-1:0]      h;
  logic [RNW-1:0]      brx;
  logic                ok_up, ok_mid, ok_dn;
  logic [RW-1:0]       up_addr, dn_addr;
  logic [CNW-1:0]      pick_col;
  pick_t               pick;
  logic                we;
  logic [RW-1:0]       waddr, raddr;
  logic [MAX_COLS-1:0] wdata, rdata;
  logic [RNW-1:0]      next_row;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (cols_q == 6'd0) begin
      w = CNW'(1);
    end else if (32'(cols_q) > MAX_COLS) begin
      w = CNW'(MAX_COLS);
    end else begin
      w = CNW'(cols_q);
    end
    if (rows_q == 6'd0) begin
      h = RNW'(1);
    end else if (32'(rows_q) > MAX_ROWS) begin
      h = RNW'(MAX_ROWS);
    end else begin
      h = RNW'(rows_q);
    end
  end

  always_comb begin
    brx     = {1'b0, br_q};
    ok_up   = (br_q != '0) && ((brx - RNW'(1)) < h);
    ok_mid  = brx < h;
    ok_dn   = (brx + RNW'(1)) < h;
    up_addr = (br_q != '0) ? br_q - RW'(1) : br_q;
    dn_addr = ((brx + RNW'(1)) < RNW'(MAX_ROWS)) ? RW'(brx + RNW'(1)) : br_q;
    pick_col = (state_q == S_EVAL) ? {1'b0, walk_col_q} : x_q;
  end

  hak_pick #(.MAX_COLS(MAX_COLS)) u_pick (
    .up_i     (up_q),
    .mid_i    (mid_q),
    .dn_i     (dn_q),
    .col_i    (pick_col),
    .w_i      (w),
    .ok_up_i  (ok_up),
    .ok_mid_i (ok_mid),
    .ok_dn_i  (ok_dn),
    .want_i   (hunting_q),
    .choice_i (choice_q),
    .pick_o   (pick)
  );

  hak_map #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    walk_col_d = walk_col_q;
    walk_row_d = walk_row_q;
    hunting_d  = hunting_q;
    hunt_row_d = hunt_row_q;
    finished_d = finished_q;
    restart_d  = restart_q;
    clr_d      = clr_q;
    br_d       = br_q;
    x_d        = x_q;
    choice_d   = choice_q;
    up_d       = up_q;
    mid_d      = mid_q;
    dn_d       = dn_q;
    ev_d       = ev_q;
    rc_d       = rc_q;
    rr_d       = rr_q;
    rd_d       = rd_q;
    rs_d       = rs_q;
    rm_d       = rm_q;
    m_tvalid_d = m_axis_tready ? 1'b0 : m_tvalid_q;
    m_tuser_d  = m_tuser_q;
    m_tdata_d  = m_tdata_q;
    we         = 1'b0;
    waddr      = br_q;
    wdata      = mid_q;
    raddr      = br_q;
    next_row   = hunt_row_q + RNW'(1);

    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = (clr_q == '0) ? oh('0) : '0;
        clr_d = clr_q + RW'(1);
        if (clr_q == RW'(MAX_ROWS - 1)) begin
          clr_d   = '0;
          state_d = restart_q ? S_RES : S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          choice_d = s_axis_tdata;
          ev_d = EV_FINISH;
          rc_d = '0;
          rr_d = '0;
          rd_d = '0;
          rs_d = '0;
          rm_d = 1'b0;
          if (s_axis_tuser == OP_RESTART) begin
            walk_col_d = '0;
            walk_row_d = '0;
            hunting_d  = 1'b0;
            hunt_row_d = '0;
            finished_d = 1'b0;
            restart_d  = 1'b1;
            clr_d      = '0;
            ev_d       = EV_RESTART;
            rm_d       = 1'b1;
            state_d    = S_CLEAR;
          end else if (finished_q) begin
            state_d = S_RES;
          end else if (hunting_q) begin
            if (hunt_row_q >= h) begin
              finished_d = 1'b1;
              state_d    = S_RES;
            end else begin
              br_d    = RW'(hunt_row_q);
              state_d = S_F0;
            end
          end else begin
            br_d    = walk_row_q;
            state_d = S_F0;
          end
        end
      end
      S_F0: begin
        raddr   = up_addr;
        state_d = S_F1;
      end
      S_F1: begin
        up_d    = rdata;
        raddr   = br_q;
        state_d = S_F2;
      end
      S_F2: begin
        mid_d   = rdata;
        raddr   = dn_addr;
        state_d = S_F3;
      end
      S_F3: begin
        dn_d    = rdata;
        x_d     = '0;
        state_d = hunting_q ? S_SCAN : S_EVAL;
      end
      S_EVAL: begin
        if (pick.found) begin
          we = 1'b1;
          case (pick.dir)
            DIR_N: begin
              waddr      = up_addr;
              wdata      = up_q | oh(walk_col_q);
              walk_row_d = up_addr;
            end
            DIR_S: begin
              waddr      = dn_addr;
              wdata      = dn_q | oh(walk_col_q);
              walk_row_d = dn_addr;
            end
            DIR_W: begin
              wdata      = mid_q | oh(walk_col_q - CW'(1));
              walk_col_d = walk_col_q - CW'(1);
            end
            default: begin
              wdata      = mid_q | oh(walk_col_q + CW'(1));
              walk_col_d = walk_col_q + CW'(1);
            end
          endcase
          ev_d    = EV_WALK;
          rc_d    = 5'(walk_col_d);
          rr_d    = 5'(walk_row_d);
          rd_d    = pick.dir ^ 2'd1;
          rm_d    = 1'b1;
          state_d = S_RES;
        end else begin
          hunting_d  = 1'b1;
          hunt_row_d = '0;
          br_d       = '0;
          state_d    = S_F0;
        end
      end
      S_SCAN: begin
        if (x_q >= w) begin
          hunt_row_d = next_row;
          if (next_row >= h) begin
            finished_d = 1'b1;
          end else begin
            ev_d = EV_EMPTY;
            rs_d = 5'(br_q);
            rm_d = 1'b1;
          end
          state_d = S_RES;
        end else if (!mid_q[x_q[CW-1:0]] && pick.found) begin
          we         = 1'b1;
          wdata      = mid_q | oh(x_q[CW-1:0]);
          walk_col_d = x_q[CW-1:0];
          walk_row_d = br_q;
          hunting_d  = 1'b0;
          ev_d       = EV_LINK;
          rc_d       = 5'(x_q);
          rr_d       = 5'(br_q);
          rd_d       = pick.dir;
          rs_d       = 5'(br_q);
          rm_d       = 1'b1;
          state_d    = S_RES;
        end else begin
          x_d = x_q + CNW'(1);
        end
      end
      S_RES: begin
        if (!m_tvalid_q || m_axis_tready) begin
          m_tvalid_d = 1'b1;
          m_tuser_d  = ev_q;
          m_tdata_d  = {6'd0, rm_q, rs_q, rd_q, rr_q, rc_q};
          restart_d  = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      cols_q     <= 6'd16;
      rows_q     <= 6'd16;
      walk_col_q <= '0;
      walk_row_q <= '0;
      hunting_q  <= 1'b0;
      hunt_row_q <= '0;
      finished_q <= 1'b0;
      restart_q  <= 1'b0;
      clr_q      <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      walk_col_q <= walk_col_d;
      walk_row_q <= walk_row_d;
      hunting_q  <= hunting_d;
      hunt_row_q <= hunt_row_d;
      finished_q <= finished_d;
      restart_q  <= restart_d;
      clr_q      <= clr_d;
      m_tvalid_q <= m_tvalid_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_COLS) begin
          cols_q <= cfg_data_i;
        end else begin
          rows_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    br_q      <= br_d;
    x_q       <= x_d;
    choice_q  <= choice_d;
    up_q      <= up_d;
    mid_q     <= mid_d;
    dn_q      <= dn_d;
    ev_q      <= ev_d;
    rc_q      <= rc_d;
    rr_q      <= rr_d;
    rd_q      <= rd_d;
    rs_q      <= rs_d;
    rm_q      <= rm_d;
    m_tuser_q <= m_tuser_d;
    m_tdata_q <= m_tdata_d;
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tuser  = m_tuser_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule

// File: rtl/hak_checker.sv
// ----------------------------------------------------------------------------
// hak_checker
// Port-level checks on the maze stepper result stream, bound to the top.
// ----------------------------------------------------------------------------
module hak_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [hak_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [2:0]                      m_axis_tuser
);
  import hak_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  a_more: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tuser == EV_FINISH) == !m_axis_tdata[17]))
    else $error("more flag disagrees with finish event");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EV_RESTART) |->
    m_axis_tdata == OUT_TDATA_W'(1) << 17)
    else $error("restart beat carries stray fields");

  a_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EV_WALK) |-> m_axis_tdata[16:12] == 5'd0)
    else $error("walk beat reports a scan row");

endmodule

bind hunt_and_kill_maze_stepper hak_checker u_hak_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
